FILE: rtl/gcp_pkg.sv
// gcp_pkg: types and constants for the image container stream parser
// used by every module in rtl; no dependencies
`timescale 1ns / 1ps

package gcp_pkg;

    typedef enum logic [4:0] {
        PH_SIG, PH_SCR, PH_GCT, PH_BLOCK, PH_DESC, PH_LCT, PH_CODE, PH_DLEN,
        PH_DATA, PH_LABEL, PH_GLEN, PH_GBODY, PH_SLEN, PH_SBODY, PH_CLEN,
        PH_CBODY, PH_ALEN, PH_AID, PH_ALEN2, PH_ALOOP, PH_DONE
    } phase_t;

    localparam logic [4:0] K_VERSION = 5'd0, K_SCR_W = 5'd1, K_SCR_H = 5'd2,
        K_BG = 5'd3, K_GCOL = 5'd4, K_LEFT = 5'd5, K_TOP = 5'd6, K_WIDTH = 5'd7,
        K_HEIGHT = 5'd8, K_LCOL = 5'd9, K_INTERLACE = 5'd10, K_CODE = 5'd11,
        K_DATA = 5'd12, K_IMG_END = 5'd13, K_DISPOSAL = 5'd14, K_DELAY = 5'd15,
        K_TRANSP = 5'd16, K_COMMENT = 5'd17, K_COMMENT_END = 5'd18,
        K_LOOP = 5'd19, K_TERM = 5'd20, K_END = 5'd21;

    localparam logic [2:0] E_OK = 3'd0, E_SIG = 3'd1, E_ZERO = 3'd2,
        E_RANGE = 3'd3, E_NOTAB = 3'd4, E_TRUNC = 3'd5;

    localparam logic [7:0] B_IMAGE = 8'h2C, B_EXT = 8'h21, B_TRAILER = 8'h3B;
    localparam logic [7:0] L_GCE = 8'hF9, L_COMMENT = 8'hFE, L_APP = 8'hFF;

    typedef struct packed {
        logic [4:0]  kind;
        logic [23:0] value;
        logic [7:0]  index;
        logic        present;
        logic [2:0]  err;
        logic        failed;
    } rec_t;

    // two records at most per byte
    typedef struct packed {
        logic [1:0] count;
        rec_t       r0;
        rec_t       r1;
    } recs_t;

    function automatic logic [7:0] sig_char(input logic [2:0] i);
        case (i)
            3'd0: sig_char = 8'h47;
            3'd1: sig_char = 8'h49;
            3'd2: sig_char = 8'h46;
            3'd3: sig_char = 8'h38;
            3'd5: sig_char = 8'h61;
            default: sig_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] app_a(input logic [3:0] i);
        case (i)
            4'd0: app_a = 8'h4E; 4'd1: app_a = 8'h45; 4'd2: app_a = 8'h54;
            4'd3: app_a = 8'h53; 4'd4: app_a = 8'h43; 4'd5: app_a = 8'h41;
            4'd6: app_a = 8'h50; 4'd7: app_a = 8'h45; 4'd8: app_a = 8'h32;
            4'd9: app_a = 8'h2E; default: app_a = 8'h30;
        endcase
    endfunction

    function automatic logic [7:0] app_b(input logic [3:0] i);
        case (i)
            4'd0: app_b = 8'h41; 4'd1: app_b = 8'h4E; 4'd2: app_b = 8'h49;
            4'd3: app_b = 8'h4D; 4'd4: app_b = 8'h45; 4'd5: app_b = 8'h58;
            4'd6: app_b = 8'h54; 4'd7: app_b = 8'h53; 4'd8: app_b = 8'h31;
            4'd9: app_b = 8'h2E; default: app_b = 8'h30;
        endcase
    endfunction

endpackage

FILE: rtl/gcp_core.sv
// gcp_core: parse state machine, one byte per cycle while step is high, up to two records out
// depends on gcp_pkg
`timescale 1ns / 1ps

module gcp_core import gcp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    input  logic [15:0] min_delay,
    output recs_t       recs
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  bif_reg, bif_next;
    logic [8:0]  pal_rem_reg, pal_rem_next;
    logic [15:0] part_reg, part_next;
    logic [15:0] scr_w_reg, scr_w_next, scr_h_reg, scr_h_next;
    logic [15:0] img_l_reg, img_l_next, img_t_reg, img_t_next, img_w_reg, img_w_next;
    logic        gts_reg, gts_next, done_img_reg, done_img_next, stop_reg, stop_next;
    logic [7:0]  gce_reg, gce_next;
    logic [1:0]  app_reg, app_next;
    logic [7:0]  pal_idx_reg, pal_idx_next;
    logic [2:0]  loop_id_reg, loop_id_next;

    logic [7:0]  b;
    logic [15:0] word;
    logic [16:0] h, lw, th;
    logic [15:0] w;
    logic [8:0]  tabsz;
    logic [8:0]  rem_dec;
    logic [2:0]  disp;
    logic [3:0]  ai;
    logic [1:0]  am;

    assign b = byte_value;
    assign word = part_reg | {b, 8'h00};
    assign tabsz = 9'd2 << b[2:0];
    assign disp = b[4:2];

    function automatic rec_t mk(input logic [4:0] k, input logic [23:0] v);
        mk = '{kind: k, value: v, index: 8'd0, present: 1'b1, err: E_OK, failed: 1'b0};
    endfunction

    always_comb begin
        rec_t o0, o1;
        logic [1:0] n;
        logic fin;
        logic [2:0] ferr;
        phase_next = phase_reg; bif_next = bif_reg; pal_rem_next = pal_rem_reg;
        part_next = part_reg; scr_w_next = scr_w_reg; scr_h_next = scr_h_reg;
        img_l_next = img_l_reg; img_t_next = img_t_reg; img_w_next = img_w_reg;
        gts_next = gts_reg; done_img_next = done_img_reg; stop_next = stop_reg;
        gce_next = gce_reg; app_next = app_reg; pal_idx_next = pal_idx_reg;
        loop_id_next = loop_id_reg;
        o0 = mk(K_VERSION, 24'd0); o1 = o0; n = 2'd0; fin = 1'b0; ferr = E_OK;
        h = 17'd0; w = 16'd0; lw = 17'd0; th = 17'd0; rem_dec = 9'd0;
        ai = 4'd0; am = 2'd0;
        case (phase_reg)
            PH_SIG: begin
                if ((bif_reg == 8'd4) ? !(b == 8'h37 || b == 8'h39)
                    : !(bif_reg < 8'd6 && b == sig_char(bif_reg[2:0]))) begin
                    fin = 1'b1; ferr = E_SIG;
                end else begin
                    if (bif_reg == 8'd4) part_next = {15'd0, b == 8'h39};
                    if (bif_reg == 8'd5) begin
                        o0 = mk(K_VERSION, {8'd0, part_reg}); n = 2'd1;
                        phase_next = PH_SCR; bif_next = 8'd0; part_next = 16'd0;
                    end else bif_next = bif_reg + 8'd1;
                end
            end
            PH_SCR: begin
                bif_next = bif_reg + 8'd1;
                case (bif_reg)
                    8'd0, 8'd2: part_next = {8'd0, b};
                    8'd1: begin scr_w_next = word; o0 = mk(K_SCR_W, {8'd0, word}); n = 2'd1; end
                    8'd3: begin scr_h_next = word; o0 = mk(K_SCR_H, {8'd0, word}); n = 2'd1; end
                    8'd4: if (b[7]) begin
                        gts_next = 1'b1; pal_rem_next = tabsz; pal_idx_next = 8'd0;
                        bif_next = 8'd5;
                    end
                    8'd5: begin
                        o0 = mk(K_BG, gts_reg ? {16'd0, b} : 24'd256); n = 2'd1;
                    end
                    default: begin
                        phase_next = gts_reg ? PH_GCT : PH_BLOCK;
                        bif_next = 8'd0; part_next = 16'd0;
                    end
                endcase
            end
            PH_GCT, PH_LCT: begin
                if (bif_reg < 8'd2) begin
                    part_next = {part_reg[7:0], b}; bif_next = bif_reg + 8'd1;
                end else begin
                    o0 = mk((phase_reg == PH_GCT) ? K_GCOL : K_LCOL, {part_reg, b});
                    o0.index = pal_idx_reg; n = 2'd1;
                    pal_idx_next = pal_idx_reg + 8'd1; bif_next = 8'd0; part_next = 16'd0;
                    rem_dec = (pal_rem_reg != 9'd0) ? pal_rem_reg - 9'd1 : 9'd0;
                    pal_rem_next = rem_dec;
                    if (rem_dec == 9'd0)
                        phase_next = (phase_reg == PH_GCT) ? PH_BLOCK : PH_CODE;
                end
            end
            PH_BLOCK: begin
                if (b == B_IMAGE) begin phase_next = PH_DESC; bif_next = 8'd0; end
                else if (b == B_EXT) phase_next = PH_LABEL;
                else if (b == B_TRAILER) begin o0 = mk(K_TERM, 24'd0); n = 2'd1; end
                else phase_next = PH_SLEN;
            end
            PH_DESC: begin
                bif_next = bif_reg + 8'd1;
                case (bif_reg)
                    8'd0, 8'd2, 8'd4, 8'd6: part_next = {8'd0, b};
                    8'd1: begin img_l_next = word; o0 = mk(K_LEFT, {8'd0, word}); n = 2'd1; end
                    8'd3: begin img_t_next = word; o0 = mk(K_TOP, {8'd0, word}); n = 2'd1; end
                    8'd5: begin
                        w = (word == 16'd0) ? scr_w_reg : word;
                        img_w_next = w; o0 = mk(K_WIDTH, {8'd0, w}); n = 2'd1;
                    end
                    8'd7: begin
                        h = {1'b0, (word == 16'd0) ? scr_h_reg : word};
                        o0 = mk(K_HEIGHT, {8'd0, h[15:0]}); n = 2'd1;
                        lw = {1'b0, img_l_reg} + {1'b0, img_w_reg};
                        th = {1'b0, img_t_reg} + h;
                        if (img_w_reg == 16'd0 || h == 17'd0) begin
                            fin = 1'b1; ferr = E_ZERO;
                        end else if (img_w_reg > scr_w_reg || img_l_reg > scr_w_reg ||
                                     lw > 17'h0FFFF || h[15:0] > scr_h_reg ||
                                     img_t_reg > scr_h_reg || th > 17'h0FFFF) begin
                            fin = 1'b1; ferr = E_RANGE;
                        end
                    end
                    default: begin
                        bif_next = bif_reg;
                        part_next = 16'd0;
                        if (b[7]) begin
                            pal_rem_next = tabsz; pal_idx_next = 8'd0; bif_next = 8'd0;
                            phase_next = PH_LCT;
                        end else if (!gts_reg) begin
                            fin = 1'b1; ferr = E_NOTAB; part_next = part_reg;
                        end else phase_next = PH_CODE;
                        if (!fin) begin
                            o0 = mk(K_INTERLACE, {23'd0, b[6]}); n = 2'd1;
                        end
                    end
                endcase
            end
            PH_CODE: begin
                o0 = mk(K_CODE, {16'd0, b}); n = 2'd1; phase_next = PH_DLEN;
            end
            PH_DLEN: begin
                if (b == 8'd0) begin
                    o0 = mk(K_IMG_END, 24'd0); n = 2'd1;
                    done_img_next = 1'b1; phase_next = PH_BLOCK;
                end else begin bif_next = b; phase_next = PH_DATA; end
            end
            PH_DATA: begin
                o0 = mk(K_DATA, {16'd0, b}); n = 2'd1;
                bif_next = bif_reg - 8'd1;
                if (bif_reg == 8'd1) phase_next = PH_DLEN;
            end
            PH_LABEL: begin
                if (b == L_GCE) phase_next = PH_GLEN;
                else if (b == L_COMMENT) phase_next = PH_CLEN;
                else if (b == L_APP) phase_next = PH_ALEN;
                else phase_next = PH_SLEN;
            end
            PH_GLEN: begin
                if (b == 8'd4) begin phase_next = PH_GBODY; bif_next = 8'd0; end
                else if (b == 8'd0) phase_next = PH_SLEN;
                else begin bif_next = b; phase_next = PH_SBODY; end
            end
            PH_GBODY: begin
                bif_next = bif_reg + 8'd1;
                case (bif_reg)
                    8'd0: begin
                        gce_next = b;
                        o0 = mk(K_DISPOSAL, {21'd0, disp[2] ? 3'd0 : disp}); n = 2'd1;
                    end
                    8'd1: part_next = {8'd0, b};
                    8'd2: begin
                        o0 = mk(K_DELAY, {8'd0, (word < min_delay) ? min_delay : word});
                        n = 2'd1; part_next = 16'd0;
                    end
                    default: begin
                        o0 = mk(K_TRANSP, gce_reg[0] ? {16'd0, b} : 24'd0);
                        o0.present = gce_reg[0]; n = 2'd1;
                        phase_next = PH_SLEN; bif_next = bif_reg;
                    end
                endcase
            end
            PH_SLEN, PH_ALEN2: begin
                if (phase_reg == PH_ALEN2 && b == 8'd3) begin
                    phase_next = PH_ALOOP; bif_next = 8'd0;
                end else if (b == 8'd0) phase_next = PH_BLOCK;
                else begin bif_next = b; phase_next = PH_SBODY; end
            end
            PH_SBODY: begin
                bif_next = bif_reg - 8'd1;
                if (bif_reg == 8'd1) phase_next = PH_SLEN;
            end
            PH_CLEN: begin
                if (b == 8'd0) begin
                    o0 = mk(K_COMMENT_END, 24'd0); n = 2'd1; phase_next = PH_BLOCK;
                end else begin bif_next = b; phase_next = PH_CBODY; end
            end
            PH_CBODY: begin
                o0 = mk(K_COMMENT, {16'd0, b}); n = 2'd1;
                bif_next = bif_reg - 8'd1;
                if (bif_reg == 8'd1) phase_next = PH_CLEN;
            end
            PH_ALEN: begin
                if (b == 8'd11) begin phase_next = PH_AID; bif_next = 8'd0; app_next = 2'b11; end
                else if (b == 8'd0) phase_next = PH_BLOCK;
                else begin bif_next = b; phase_next = PH_SBODY; end
            end
            PH_AID: begin
                ai = (bif_reg > 8'd10) ? 4'd10 : bif_reg[3:0];
                am = app_reg;
                if (b != app_a(ai)) am = am & 2'b10;
                if (b != app_b(ai)) am = am & 2'b01;
                app_next = am;
                if (bif_reg >= 8'd10) phase_next = (am != 2'b00) ? PH_ALEN2 : PH_SLEN;
                else bif_next = bif_reg + 8'd1;
            end
            PH_ALOOP: begin
                if (bif_reg == 8'd0) begin loop_id_next = b[2:0]; bif_next = 8'd1; end
                else if (bif_reg == 8'd1) begin part_next = {8'd0, b}; bif_next = 8'd2; end
                else begin
                    if (loop_id_reg == 3'd1) begin o0 = mk(K_LOOP, {8'd0, word}); n = 2'd1; end
                    part_next = 16'd0; phase_next = PH_SLEN;
                end
            end
            default: ;
        endcase
        // truncation or normal end on the final byte
        if (!fin && last_byte) begin
            fin = 1'b1;
            ferr = (phase_next == PH_BLOCK) ? E_OK : E_TRUNC;
        end
        if (fin) begin
            o1 = mk(K_END, 24'd0);
            o1.err = ferr;
            o1.failed = (ferr != E_OK) && !done_img_next;
            if (n == 2'd0) begin o0 = o1; n = 2'd1; end
            else n = 2'd2;
            stop_next = 1'b1; phase_next = PH_DONE;
        end
        if (stop_reg) n = 2'd0;
        recs.count = n; recs.r0 = o0; recs.r1 = o1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SIG; bif_reg <= 8'd0; pal_rem_reg <= 9'd0; part_reg <= 16'd0;
            scr_w_reg <= 16'd0; scr_h_reg <= 16'd0; img_l_reg <= 16'd0;
            img_t_reg <= 16'd0; img_w_reg <= 16'd0; gts_reg <= 1'b0;
            done_img_reg <= 1'b0; stop_reg <= 1'b0; gce_reg <= 8'd0;
            app_reg <= 2'b11; pal_idx_reg <= 8'd0; loop_id_reg <= 3'd0;
        end else if (step && !stop_reg) begin
            phase_reg <= phase_next; bif_reg <= bif_next; pal_rem_reg <= pal_rem_next;
            part_reg <= part_next; scr_w_reg <= scr_w_next; scr_h_reg <= scr_h_next;
            img_l_reg <= img_l_next; img_t_reg <= img_t_next; img_w_reg <= img_w_next;
            gts_reg <= gts_next; done_img_reg <= done_img_next; stop_reg <= stop_next;
            gce_reg <= gce_next; app_reg <= app_next; pal_idx_reg <= pal_idx_next;
            loop_id_reg <= loop_id_next;
        end
    end

endmodule

FILE: rtl/gcp_out_queue.sv
// gcp_out_queue: four-entry record fifo feeding the master stream
// depends on gcp_pkg
`timescale 1ns / 1ps

module gcp_out_queue import gcp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  recs_t recs,
    output logic  room,
    output logic  out_valid,
    input  logic  out_ready,
    output rec_t  out_rec
);

    rec_t       mem_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;
    logic [1:0] n_in;
    logic       pop;

    assign n_in = push ? recs.count : 2'd0;
    assign pop = out_valid && out_ready;
    // room for two more even before the head leaves
    assign room = cnt_reg <= 3'd2;
    assign out_valid = cnt_reg != 3'd0;
    assign out_rec = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (n_in != 2'd0) mem_reg[wr_reg] <= recs.r0;
        if (n_in == 2'd2) mem_reg[wr_reg + 2'd1] <= recs.r1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg <= 2'd0; wr_reg <= 2'd0; cnt_reg <= 3'd0;
        end else begin
            wr_reg <= wr_reg + n_in;
            if (pop) rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + {1'b0, n_in} - {2'b00, pop};
        end
    end

endmodule

FILE: rtl/gif_container_parser_unit.sv
// gif_container_parser_unit: top level of the image container stream parser
// depends on gcp_pkg, gcp_core, gcp_out_queue
`timescale 1ns / 1ps

// Takes one file byte per transaction and emits field records on the master
// stream. One byte is taken every cycle while the four-entry record queue
// has room for two records; each byte yields zero, one or two records, and
// a byte that produces records sustains one per cycle when the sink keeps up.
// Records are held in the record queue registers. The delay floor register is
// written on the cfg channel, which is always ready.

module gif_container_parser_unit import gcp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // record_value, entry_index, value_present,
                                   // error_code, parse_failed
    output logic [4:0]  m_tuser,   // record_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // min_frame_delay
);

    logic [15:0] min_delay_reg;
    logic        room, step;
    recs_t       recs;
    rec_t        rec;

    assign cfg_ready = 1'b1;
    assign s_tready = room;
    assign step = s_tvalid && room;

    always_ff @(posedge aclk) begin
        if (!aresetn) min_delay_reg <= 16'd10;
        else if (cfg_valid) min_delay_reg <= cfg_data;
    end

    gcp_core u_core (
        .aclk(aclk), .aresetn(aresetn), .step(step), .byte_value(s_tdata),
        .last_byte(s_tlast), .min_delay(min_delay_reg), .recs(recs)
    );

    gcp_out_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(step), .recs(recs), .room(room),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_rec(rec)
    );

    assign m_tuser = rec.kind;
    assign m_tdata = {3'd0, rec.failed, rec.err, rec.present, rec.index, rec.value};

endmodule
